[rtl/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge; ignored while reset is held.
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/ple_pkg.sv]
// Types, codes and constants shared by the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int unsigned DEPTH_DEF   = 256;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_GET    = 3'd1,
    CMD_LOCATE = 3'd2,
    CMD_PRIOR  = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_INSERT = 3'd5,
    CMD_DELETE = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    RES_OK,
    RES_BADPOS,
    RES_NOTFOUND,
    RES_FULL,
    RES_VAL,
    RES_POS
  } res_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_e;

  typedef enum logic {
    HOLD_RDATA,
    HOLD_PREV
  } hsrc_e;

  typedef struct packed {
    logic  load_in;
    logic  walk_start;
    logic  rd_en;
    logic  shift_wr;
    logic  ins_wr;
    cnt_e  cnt_op;
    logic  hold_en;
    hsrc_e hold_src;
    logic  res_ld;
    res_e  res_sel;
  } ple_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_ok_rd;
    logic             pos_ok_ins;
    logic             full;
    logic             empty;
    logic             append;
    logic             issue_last;
    logic             cmp_vld;
    logic             cmp_first;
    logic             cmp_last;
    logic             hit;
  } ple_stat_t;

endpackage

`default_nettype wire

[rtl/ple_datapath.sv]
// List store, walk counter, read pipeline, compare and result registers.
`default_nettype none
`include "assert_macros.svh"

module ple_datapath import ple_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [POS_W-1:0]  pos_i,
  input  wire logic [VAL_W-1:0]  val_i,
  input  wire ple_ctl_t          ctl_i,
  output ple_stat_t              stat_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [VAL_W-1:0]       value_o,
  output logic [POS_W-1:0]       position_o,
  output logic [POS_W-1:0]       length_o,
  output logic                   empty_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CMD_W-1:0] cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [CW-1:0]    count_q, count_d;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [AW-1:0]    idx_q, idx_d, end_q, end_d;
  logic             up_q, up_d;
  logic [VAL_W-1:0] rdata_q, prev_q;
  logic [AW-1:0]    rtag_q;
  logic             rvld_q, rlast_q;
  logic [VAL_W-1:0] hold_val_q;
  logic [POS_W-1:0] hold_pos_q;

  logic [CMP_W-1:0] pos_w, posm1_w, n_w, nm1_w, tag_w, tag_p1_w;
  logic [AW-1:0]    posm1_a, nm1_a, tag_m1_a;
  logic             is_ins, is_del, eq, hit;
  logic             we, shift_we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  assign pos_w    = CMP_W'(pos_q);
  assign posm1_w  = pos_w - CMP_W'(1);
  assign n_w      = CMP_W'(count_q);
  assign nm1_w    = n_w - CMP_W'(1);
  assign tag_w    = CMP_W'(rtag_q);
  assign tag_p1_w = tag_w + CMP_W'(1);
  assign posm1_a  = posm1_w[AW-1:0];
  assign nm1_a    = nm1_w[AW-1:0];
  assign tag_m1_a = rtag_q - AW'(1);

  assign is_ins = (cmd_q == CMD_INSERT);
  assign is_del = (cmd_q == CMD_DELETE);
  assign eq     = (rdata_q == val_q);

  always_comb begin
    case (cmd_q)
      CMD_LOCATE: hit = eq;
      CMD_PRIOR:  hit = eq && (rtag_q != '0);
      CMD_NEXT:   hit = eq && !rlast_q;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.pos_ok_rd  = (pos_w != '0) && (pos_w <= n_w);
    stat_o.pos_ok_ins = (pos_w != '0) && (pos_w <= n_w + CMP_W'(1));
    stat_o.full       = (n_w >= CMP_W'(DEPTH));
    stat_o.empty      = (count_q == '0);
    stat_o.append     = (posm1_w == n_w);
    stat_o.issue_last = (idx_q == end_q);
    stat_o.cmp_vld    = rvld_q;
    stat_o.cmp_first  = (rtag_q == posm1_a);
    stat_o.cmp_last   = rlast_q;
    stat_o.hit        = rvld_q && hit;
  end

  // walk bounds per command
  always_comb begin
    idx_d = idx_q;
    end_d = end_q;
    up_d  = up_q;
    if (ctl_i.walk_start) begin
      case (cmd_q)
        CMD_GET: begin
          idx_d = posm1_a;
          end_d = posm1_a;
          up_d  = 1'b1;
        end
        CMD_INSERT: begin
          idx_d = nm1_a;
          end_d = posm1_a;
          up_d  = 1'b0;
        end
        CMD_DELETE: begin
          idx_d = posm1_a;
          end_d = nm1_a;
          up_d  = 1'b1;
        end
        default: begin
          idx_d = '0;
          end_d = nm1_a;
          up_d  = 1'b1;
        end
      endcase
    end else if (ctl_i.rd_en) begin
      idx_d = up_q ? idx_q + AW'(1) : idx_q - AW'(1);
    end
  end

  always_comb begin
    case (ctl_i.cnt_op)
      CNT_CLEAR: count_d = '0;
      CNT_INC:   count_d = count_q + CW'(1);
      CNT_DEC:   count_d = count_q - CW'(1);
      default:   count_d = count_q;
    endcase
  end

  // insert moves entries up, delete moves them down; the removed item is skipped
  assign shift_we = ctl_i.shift_wr && rvld_q &&
                    (is_ins || (is_del && (rtag_q != posm1_a)));
  assign we       = shift_we || ctl_i.ins_wr;
  assign waddr    = ctl_i.ins_wr ? posm1_a : (is_ins ? tag_p1_w[AW-1:0] : tag_m1_a);
  assign wdata    = ctl_i.ins_wr ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[idx_q];
      rtag_q  <= idx_q;
      rlast_q <= (idx_q == end_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      rvld_q  <= ctl_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    end_q <= end_d;
    up_q  <= up_d;
    if (ctl_i.load_in) begin
      cmd_q <= cmd_i;
      pos_q <= pos_i;
      val_q <= val_i;
    end
    if (rvld_q) begin
      prev_q <= rdata_q;
    end
    if (ctl_i.hold_en) begin
      hold_val_q <= (ctl_i.hold_src == HOLD_PREV) ? prev_q : rdata_q;
      hold_pos_q <= tag_p1_w[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_ld) begin
      value_o    <= '0;
      position_o <= '0;
      length_o   <= n_w[POS_W-1:0];
      empty_o    <= (count_q == '0);
      case (ctl_i.res_sel)
        RES_BADPOS:   status_o <= STAT_BADPOS;
        RES_NOTFOUND: status_o <= STAT_NOTFOUND;
        RES_FULL:     status_o <= STAT_FULL;
        RES_VAL: begin
          status_o <= STAT_OK;
          value_o  <= hold_val_q;
        end
        RES_POS: begin
          status_o   <= STAT_OK;
          position_o <= hold_pos_q;
        end
        default:      status_o <= STAT_OK;
      endcase
    end
  end

  `PLE_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `PLE_ASSERT(a_no_rw_clash, (we && ctl_i.rd_en) |-> (waddr != idx_q),
    "write and read hit the same slot")

endmodule

`default_nettype wire

[rtl/ple_ctrl.sv]
// Command sequencer: handshakes, decode, walk control and result hand-off.
`default_nettype none
`include "assert_macros.svh"

module ple_ctrl import ple_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ple_stat_t stat_i,
  output ple_ctl_t       ctl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DEC   = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_NEXT  = 3'd4;
  localparam logic [2:0] ST_INS   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  res_e       kind_q, kind_d;
  logic       out_vld_q, out_vld_d;
  logic       acc, moved;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    ctl_o   = '0;
    moved   = 1'b0;

    unique case (state_q) inside
      ST_IDLE: begin
        if (acc) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_DEC;
        end
      end

      ST_DEC: begin
        unique case (stat_i.cmd) inside
          CMD_CLEAR: begin
            ctl_o.cnt_op = CNT_CLEAR;
            kind_d       = RES_OK;
            state_d      = ST_OUT;
          end
          CMD_GET, CMD_DELETE: begin
            if (!stat_i.pos_ok_rd) begin
              kind_d  = RES_BADPOS;
              state_d = ST_OUT;
            end else begin
              ctl_o.walk_start = 1'b1;
              state_d          = ST_WALK;
            end
          end
          CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
            if (stat_i.empty) begin
              kind_d  = RES_NOTFOUND;
              state_d = ST_OUT;
            end else begin
              ctl_o.walk_start = 1'b1;
              state_d          = ST_WALK;
            end
          end
          CMD_INSERT: begin
            if (!stat_i.pos_ok_ins) begin
              kind_d  = RES_BADPOS;
              state_d = ST_OUT;
            end else if (stat_i.full) begin
              kind_d  = RES_FULL;
              state_d = ST_OUT;
            end else if (stat_i.append) begin
              state_d = ST_INS;
            end else begin
              ctl_o.walk_start = 1'b1;
              state_d          = ST_WALK;
            end
          end
          default: begin
            kind_d  = RES_OK;
            state_d = ST_OUT;
          end
        endcase
      end

      ST_WALK, ST_DRAIN: begin
        ctl_o.rd_en    = (state_q == ST_WALK);
        ctl_o.shift_wr = 1'b1;
        if (stat_i.cmp_vld) begin
          case (stat_i.cmd) inside
            CMD_GET: begin
              ctl_o.hold_en = 1'b1;
              kind_d        = RES_VAL;
              state_d       = ST_OUT;
              moved         = 1'b1;
            end
            CMD_LOCATE, CMD_PRIOR: begin
              if (stat_i.hit) begin
                ctl_o.hold_en  = 1'b1;
                ctl_o.hold_src = (stat_i.cmd == CMD_PRIOR) ? HOLD_PREV : HOLD_RDATA;
                kind_d         = (stat_i.cmd == CMD_PRIOR) ? RES_VAL : RES_POS;
                state_d        = ST_OUT;
                moved          = 1'b1;
              end else if (stat_i.cmp_last) begin
                kind_d  = RES_NOTFOUND;
                state_d = ST_OUT;
                moved   = 1'b1;
              end
            end
            CMD_NEXT: begin
              if (stat_i.hit) begin
                state_d = ST_NEXT;
                moved   = 1'b1;
              end else if (stat_i.cmp_last) begin
                kind_d  = RES_NOTFOUND;
                state_d = ST_OUT;
                moved   = 1'b1;
              end
            end
            CMD_DELETE: begin
              ctl_o.hold_en = stat_i.cmp_first;
              if (stat_i.cmp_last) begin
                ctl_o.cnt_op = CNT_DEC;
                kind_d       = RES_VAL;
                state_d      = ST_OUT;
                moved        = 1'b1;
              end
            end
            CMD_INSERT: begin
              if (stat_i.cmp_last) begin
                state_d = ST_INS;
                moved   = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (!moved && (state_q == ST_WALK) && stat_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end

      // successor word lands in the cycle after the match
      ST_NEXT: begin
        ctl_o.hold_en = 1'b1;
        kind_d        = RES_VAL;
        state_d       = ST_OUT;
      end

      ST_INS: begin
        ctl_o.ins_wr = 1'b1;
        ctl_o.cnt_op = CNT_INC;
        kind_d       = RES_OK;
        state_d      = ST_OUT;
      end

      ST_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          ctl_o.res_ld  = 1'b1;
          ctl_o.res_sel = kind_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = ctl_o.res_ld || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      kind_q    <= RES_OK;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      kind_q    <= kind_d;
    end
  end

  `PLE_ASSERT(a_res_slot_free, ctl_o.res_ld |-> (!out_vld_q || out_ready_i),
    "result loaded over a pending item")
  `PLE_ASSERT(a_accept_decodes, acc |=> (state_q == ST_DEC),
    "accepted item not decoded next cycle")

endmodule

`default_nettype wire

[rtl/positional_list_engine.sv]
// Positional list engine top level: stream ports, sequencer and datapath.
//
//  channel   dir  payload (lsb first)                                            width
//  s_axis    in   command[2:0] position[11:3] value[43:12] zero[47:44]             48
//  m_axis    out  status[1:0] value_out[33:2] position_out[42:34]
//                 list_length[51:43] is_empty[52] zero[55:53]                      56
//
//  Clear and rejected commands go straight to the result; get reads its one slot.
//  Locate, prior and next walk the list from the front, one slot read per cycle.
//  Insert walks from the tail down to the position and appending skips the walk; delete
//  walks from the position to the tail; one slot moved per cycle.
//  rst_ni clears the length and the handshake state; the store needs no clearing pass.
//  One item in flight; a result waiting in the output register stalls only the hand-off.
`default_nettype none

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // command, position, value
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // status, value_out, position_out,
                                                     // list_length, is_empty
);

  ple_ctl_t          ctl;
  ple_stat_t         stat;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  value_out;
  logic [POS_W-1:0]  position_out;
  logic [POS_W-1:0]  list_length;
  logic              is_empty;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (s_axis_tdata[CMD_W-1:0]),
    .pos_i      (s_axis_tdata[CMD_W+POS_W-1:CMD_W]),
    .val_i      (s_axis_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .status_o   (status),
    .value_o    (value_out),
    .position_o (position_out),
    .length_o   (list_length),
    .empty_o    (is_empty)
  );

  assign m_axis_tdata = {3'b000, is_empty, list_length, position_out, value_out, status};

endmodule

`default_nettype wire
